// ===== sv/matrix4_compose_and_transform_defines.svh =====
// Assertion macros used by the port-level checker of the matrix compose unit.
// Depends on nothing; the user supplies clk and rst_n in the scope of each use.
`ifndef MATRIX4_COMPOSE_AND_TRANSFORM_DEFINES_SVH
`define MATRIX4_COMPOSE_AND_TRANSFORM_DEFINES_SVH

// Antecedent in one cycle implies consequent in the next cycle.
`define M4CT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m4ct check failed");

// Antecedent implies consequent in the same cycle.
`define M4CT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m4ct check failed");

`endif

// ===== sv/m4ct_pkg.sv =====
// Package for the 4x4 matrix compose and transform unit: payload types,
// opcodes, lane control and default widths. No dependencies.
`default_nettype none

package m4ct_pkg;

    localparam int FIELD_WIDTH    = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int DIM            = 4;

    typedef enum logic [2:0] {
        OP_IDENT     = 3'd0,
        OP_LOAD      = 3'd1,
        OP_RMUL      = 3'd2,
        OP_LMUL      = 3'd3,
        OP_TRANSPOSE = 3'd4,
        OP_XFORM     = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]                    op;
        logic [1:0]                    row;
        logic signed [FIELD_WIDTH-1:0] elem_0;
        logic signed [FIELD_WIDTH-1:0] elem_1;
        logic signed [FIELD_WIDTH-1:0] elem_2;
        logic signed [FIELD_WIDTH-1:0] elem_3;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] out_0;
        logic signed [FIELD_WIDTH-1:0] out_1;
        logic signed [FIELD_WIDTH-1:0] out_2;
        logic signed [FIELD_WIDTH-1:0] out_3;
        logic                          clipped;
    } out_item_t;

    // Control shared by all four lanes.
    typedef struct packed {
        logic en;       // pipeline advances this cycle
        logic issue;    // a multiply is issued this cycle
        logic b_valid;  // the product register holds a term
        logic b_first;  // that term starts a new dot product
    } lane_ctl_t;

endpackage

`default_nettype wire

// ===== sv/m4ct_lane.sv =====
// One column lane: a registered signed multiplier with fraction truncation,
// an exact accumulator and saturation. Depends on m4ct_pkg.
`default_nettype none

module m4ct_lane
    import m4ct_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  lane_ctl_t                    ctl,
    input  logic signed [ELEM_WIDTH-1:0] a,
    input  logic signed [ELEM_WIDTH-1:0] b,
    output logic signed [ELEM_WIDTH-1:0] res,
    output logic                         sat
);

    localparam int FW = 2 * ELEM_WIDTH;
    localparam int PW = FW - FRAC_BITS;
    localparam int AW = PW + 2;

    logic signed [FW-1:0] full;
    logic signed [FW-1:0] shifted;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic                 ovf;

    assign full      = a * b;
    assign shifted   = full >>> FRAC_BITS;
    assign prod_next = shifted[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.en && ctl.issue)
        begin
            prod_reg <= prod_next;
        end
    end

    // The sum of four truncated products is exact in AW bits.
    assign acc_next = (ctl.b_first ? {AW{1'b0}} : acc_reg)
                    + {{2{prod_reg[PW-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.en && ctl.b_valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign ovf = acc_next[AW-1:ELEM_WIDTH-1] != {(AW-ELEM_WIDTH+1){acc_next[AW-1]}};
    assign sat = ovf;

    always_comb
    begin
        if (!ovf)
        begin
            res = acc_next[ELEM_WIDTH-1:0];
        end
        else if (acc_next[AW-1])
        begin
            res = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// ===== sv/m4ct_merge.sv =====
// Merging stage: gathers the four lane results of a transform into one
// result transaction, folds the saturation flags and holds the output register.
// Depends on m4ct_pkg.
`default_nettype none

module m4ct_merge
    import m4ct_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr,
    input  logic signed [ELEM_WIDTH-1:0] col [DIM],
    input  logic [DIM-1:0]               col_sat,
    input  logic                         result_stall,
    output logic                         result_valid,
    output out_item_t                    result,
    output logic                         slot_full
);

    logic signed [FIELD_WIDTH-1:0] col32 [DIM];
    logic                          valid_reg;
    logic                          valid_next;
    out_item_t                     data_reg;
    out_item_t                     data_next;

    for (genvar j = 0; j < DIM; j++)
    begin : g_col
        if (ELEM_WIDTH >= FIELD_WIDTH)
        begin : g_trunc
            assign col32[j] = col[j][FIELD_WIDTH-1:0];
        end
        else
        begin : g_ext
            assign col32[j] = {{(FIELD_WIDTH-ELEM_WIDTH){col[j][ELEM_WIDTH-1]}}, col[j]};
        end
    end

    assign data_next = '{out_0: col32[0], out_1: col32[1], out_2: col32[2],
                         out_3: col32[3], clipped: |col_sat};

    assign valid_next = wr | (valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            data_reg <= data_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;
    assign slot_full    = valid_reg & result_stall;

endmodule

`default_nettype wire

// ===== sv/matrix4_compose_and_transform.sv =====
// Top level of the 4x4 fixed-point matrix compose and transform unit.
// Depends on m4ct_pkg, m4ct_lane and m4ct_merge.
//
// The unit holds a 4x4 signed fixed-point matrix (Q16.16 by default), row
// major, reset to identity. Each input transaction carries an opcode, a row
// index and four elements. Identity, load row, transpose of the upper-left
// 3x3 and operand rows 0 to 2 of a multiply take effect in the cycle they
// are accepted, and the next transaction can follow in the very next cycle.
// Operand row 3 commits current*operand or operand*current: four column
// lanes, each with one multiplier, issue the multiplies one term at a time,
// and input is held off until the new matrix is written at the end of the
// cycle after the last issue. A transform runs its four multiplies per
// column in the same lanes; a new transform can be accepted in the last
// issue cycle of the one before, and each result transaction appears in a
// registered output stage, so the unit keeps taking input while a finished
// result waits to be taken, until the next transform result is ready. Each
// product is truncated toward minus infinity at the fraction point, each
// four-term sum is exact and then saturated to the element width; only a
// transform reports saturation, through the clipped flag. Opcodes 6 and 7
// are accepted and ignored.
`default_nettype none

module matrix4_compose_and_transform
    import m4ct_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam logic signed [ELEM_WIDTH-1:0] ONE =
        {{(ELEM_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

    // Element storage: the current matrix and the operand buffer. The
    // operand buffer keeps its rows after a commit, so a later lone last row
    // commits again with them. Finished rows 0 to 2 of a left multiply wait
    // in their own registers until the commit copies them over.
    logic signed [ELEM_WIDTH-1:0] mat_reg  [DIM][DIM];
    logic signed [ELEM_WIDTH-1:0] mat_next [DIM][DIM];
    logic signed [ELEM_WIDTH-1:0] buf_reg  [DIM][DIM];
    logic signed [ELEM_WIDTH-1:0] buf_next [DIM][DIM];
    logic signed [ELEM_WIDTH-1:0] lrow_reg [DIM-1][DIM];

    // Issue stage of the sequencer.
    logic                         busy_reg, busy_next;
    logic                         xform_reg, xform_next;
    logic                         left_reg, left_next;
    logic [3:0]                   cnt_reg, cnt_next;
    logic signed [ELEM_WIDTH-1:0] vec_reg [DIM];

    // Tags that travel with the product registers in the lanes.
    logic       bv_reg, bfirst_reg, blast_reg, bxform_reg, bleft_reg, bfinal_reg;
    logic [1:0] brow_reg;

    logic signed [ELEM_WIDTH-1:0] in_elem [DIM];
    logic signed [FIELD_WIDTH-1:0] raw_elem [DIM];
    logic signed [ELEM_WIDTH-1:0] lane_a;
    logic signed [ELEM_WIDTH-1:0] lane_b   [DIM];
    logic signed [ELEM_WIDTH-1:0] lane_res [DIM];
    logic [DIM-1:0]               lane_sat;
    lane_ctl_t                    lane_ctl;

    logic [1:0] k_idx;
    logic [1:0] i_idx;
    logic       issue_last;
    logic       slot_full;
    logic       stall_pipe;
    logic       en;
    logic       commit_final;
    logic       acc_item;
    logic       starts;
    logic       is_mul_op;
    logic       row_wr;
    logic       out_wr;

    assign raw_elem[0] = item.elem_0;
    assign raw_elem[1] = item.elem_1;
    assign raw_elem[2] = item.elem_2;
    assign raw_elem[3] = item.elem_3;

    // Input elements are 32-bit fields; a narrower element width saturates
    // them silently, a wider one sign-extends them.
    for (genvar e = 0; e < DIM; e++)
    begin : g_in
        if (ELEM_WIDTH > FIELD_WIDTH)
        begin : g_wide
            assign in_elem[e] = {{(ELEM_WIDTH-FIELD_WIDTH){raw_elem[e][FIELD_WIDTH-1]}},
                                 raw_elem[e]};
        end
        else if (ELEM_WIDTH == FIELD_WIDTH)
        begin : g_same
            assign in_elem[e] = raw_elem[e];
        end
        else
        begin : g_narrow
            always_comb
            begin
                if (raw_elem[e][FIELD_WIDTH-1:ELEM_WIDTH-1]
                    == {(FIELD_WIDTH-ELEM_WIDTH+1){raw_elem[e][FIELD_WIDTH-1]}})
                begin
                    in_elem[e] = raw_elem[e][ELEM_WIDTH-1:0];
                end
                else if (raw_elem[e][FIELD_WIDTH-1])
                begin
                    in_elem[e] = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
                end
                else
                begin
                    in_elem[e] = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
                end
            end
        end
    end

    // The count walks k (the term of the dot product) fastest and i (the
    // result row of a multiply) slowest. A transform only uses k.
    assign k_idx      = cnt_reg[1:0];
    assign i_idx      = cnt_reg[3:2];
    assign issue_last = xform_reg ? (k_idx == 2'd3) : (cnt_reg == 4'd15);

    // The whole pipeline freezes only when a transform result is ready and
    // the output register is still occupied.
    assign stall_pipe   = slot_full & bv_reg & blast_reg & bxform_reg;
    assign en           = ~stall_pipe;
    assign commit_final = bv_reg & bfinal_reg & ~bxform_reg;

    // A new transaction may enter in the last issue cycle of a transform;
    // the matrix is only read during issue. A commit holds input off until
    // its last row has been written back.
    assign item_stall = stall_pipe | commit_final
                      | (busy_reg & ~(xform_reg & (k_idx == 2'd3)));
    assign acc_item   = item_valid & ~item_stall;
    assign is_mul_op  = (item.op == OP_RMUL) || (item.op == OP_LMUL);
    assign starts     = acc_item & ((item.op == OP_XFORM) | (is_mul_op & (item.row == 2'd3)));

    always_comb
    begin
        busy_next  = busy_reg;
        xform_next = xform_reg;
        left_next  = left_reg;
        cnt_next   = cnt_reg;
        if (starts)
        begin
            busy_next  = 1'b1;
            xform_next = (item.op == OP_XFORM);
            left_next  = (item.op == OP_LMUL);
            cnt_next   = 4'd0;
        end
        else if (busy_reg && en)
        begin
            cnt_next = cnt_reg + 4'd1;
            if (issue_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            xform_reg  <= 1'b0;
            left_reg   <= 1'b0;
            cnt_reg    <= 4'd0;
            bv_reg     <= 1'b0;
            bfirst_reg <= 1'b0;
            blast_reg  <= 1'b0;
            bxform_reg <= 1'b0;
            bleft_reg  <= 1'b0;
            bfinal_reg <= 1'b0;
            brow_reg   <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            xform_reg <= xform_next;
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
            if (en)
            begin
                bv_reg     <= busy_reg;
                bfirst_reg <= (k_idx == 2'd0);
                blast_reg  <= (k_idx == 2'd3);
                bxform_reg <= xform_reg;
                bleft_reg  <= left_reg;
                bfinal_reg <= busy_reg & issue_last;
                brow_reg   <= i_idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_item && (item.op == OP_XFORM))
        begin
            vec_reg <= in_elem;
        end
    end

    // Operand selection. Lane j always produces column j of the result.
    // Transform: v[k] * M[k][j]. Right multiply: M[i][k] * P[k][j].
    // Left multiply: P[i][k] * M[k][j].
    always_comb
    begin
        if (xform_reg)
        begin
            lane_a = vec_reg[k_idx];
        end
        else if (left_reg)
        begin
            lane_a = buf_reg[i_idx][k_idx];
        end
        else
        begin
            lane_a = mat_reg[i_idx][k_idx];
        end
        for (int j = 0; j < DIM; j++)
        begin
            lane_b[j] = (!xform_reg && !left_reg) ? buf_reg[k_idx][j] : mat_reg[k_idx][j];
        end
    end

    assign lane_ctl = '{en: en, issue: busy_reg, b_valid: bv_reg, b_first: bfirst_reg};

    for (genvar j = 0; j < DIM; j++)
    begin : g_lane
        m4ct_lane #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk (clk),
            .ctl (lane_ctl),
            .a   (lane_a),
            .b   (lane_b[j]),
            .res (lane_res[j]),
            .sat (lane_sat[j])
        );
    end

    assign row_wr = en & bv_reg & blast_reg & ~bxform_reg;
    assign out_wr = en & bv_reg & blast_reg & bxform_reg;

    // Matrix and buffer updates. Writes from accepted transactions and
    // write-back of multiply rows never fall in the same cycle.
    always_comb
    begin
        mat_next = mat_reg;
        buf_next = buf_reg;
        if (acc_item)
        begin
            unique case (item.op)
                OP_IDENT:
                begin
                    for (int r = 0; r < DIM; r++)
                    begin
                        for (int c = 0; c < DIM; c++)
                        begin
                            mat_next[r][c] = (r == c) ? ONE : '0;
                        end
                    end
                end
                OP_LOAD:
                begin
                    for (int c = 0; c < DIM; c++)
                    begin
                        mat_next[item.row][c] = in_elem[c];
                    end
                end
                OP_RMUL, OP_LMUL:
                begin
                    for (int c = 0; c < DIM; c++)
                    begin
                        buf_next[item.row][c] = in_elem[c];
                    end
                end
                OP_TRANSPOSE:
                begin
                    mat_next[0][1] = mat_reg[1][0];
                    mat_next[1][0] = mat_reg[0][1];
                    mat_next[0][2] = mat_reg[2][0];
                    mat_next[2][0] = mat_reg[0][2];
                    mat_next[1][2] = mat_reg[2][1];
                    mat_next[2][1] = mat_reg[1][2];
                end
                default:
                begin
                end
            endcase
        end
        if (row_wr)
        begin
            if (!bleft_reg)
            begin
                // Row i of current*operand depends only on row i of current.
                for (int c = 0; c < DIM; c++)
                begin
                    mat_next[brow_reg][c] = lane_res[c];
                end
            end
            else if (bfinal_reg)
            begin
                for (int r = 0; r < DIM - 1; r++)
                begin
                    for (int c = 0; c < DIM; c++)
                    begin
                        mat_next[r][c] = lrow_reg[r][c];
                    end
                end
                for (int c = 0; c < DIM; c++)
                begin
                    mat_next[DIM-1][c] = lane_res[c];
                end
            end
        end
    end

    // Every row of operand*current reads the whole current matrix, so the
    // finished rows wait here until the commit.
    always_ff @(posedge clk)
    begin
        if (row_wr && bleft_reg && !bfinal_reg)
        begin
            lrow_reg[brow_reg] <= lane_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                for (int c = 0; c < DIM; c++)
                begin
                    mat_reg[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end
        else
        begin
            mat_reg <= mat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    m4ct_merge #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (out_wr),
        .col          (lane_res),
        .col_sat      (lane_sat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .slot_full    (slot_full)
    );

endmodule

`default_nettype wire

// ===== sv/m4ct_checker.sv =====
// Port-level checks for the matrix compose unit, bound to the top level.
// Depends on m4ct_pkg and matrix4_compose_and_transform_defines.svh.
`default_nettype none
`include "matrix4_compose_and_transform_defines.svh"

module m4ct_checker
    import m4ct_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_stall,
    input in_item_t  item,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    logic take_xform;
    logic take_commit;

    assign take_xform  = item_valid && !item_stall && (item.op == OP_XFORM);
    assign take_commit = item_valid && !item_stall && (item.row == 2'd3)
                      && ((item.op == OP_RMUL) || (item.op == OP_LMUL));

    // A stalled result transaction stays in place.
    `M4CT_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

    // A transform keeps the lanes busy, so input must stall next.
    `M4CT_ASSERT_NEXT(a_xform_busy, take_xform, item_stall)

    // A committing operand row starts the long multiply; input must stall next.
    `M4CT_ASSERT_NEXT(a_commit_busy, take_commit, item_stall)

    // Checks that a result reporting saturation is offered; its antecedent already implies this.
    `M4CT_ASSERT_SAME(a_clip_valid, result_valid && result.clipped, result_valid)

endmodule

bind matrix4_compose_and_transform m4ct_checker u_m4ct_checker (.*);

`default_nettype wire
